>>> sv/twr_pkg.sv
// shared constants and types for the two-way ranging time-of-flight block
package twr_pkg;

    localparam int STAMP_BITS = 40;
    localparam int HALF_BITS  = STAMP_BITS / 2;
    localparam int DEN_BITS   = STAMP_BITS + 2;
    localparam int PROD_BITS  = 2 * STAMP_BITS;
    localparam int OUT_BITS   = 41;
    localparam int CMP_BITS   = (STAMP_BITS + 1 > OUT_BITS) ? STAMP_BITS + 1 : OUT_BITS;

    localparam logic [CMP_BITS-1:0] POS_LIMIT =
        (CMP_BITS'(1) << (OUT_BITS - 1)) - CMP_BITS'(1);
    localparam logic [CMP_BITS-1:0] NEG_LIMIT = CMP_BITS'(1) << (OUT_BITS - 1);

    localparam logic METHOD_ASYM = 1'b0;
    localparam logic METHOD_SYM  = 1'b1;

    // payload of one divider stage plus sideband that rides along
    typedef struct packed {
        logic [DEN_BITS-1:0]   rem;
        logic [STAMP_BITS-1:0] low;
        logic [STAMP_BITS-1:0] quo;
        logic [DEN_BITS-1:0]   den;
        logic                  neg;
        logic                  zdiv;
        logic                  sym;
        logic                  sym_neg;
        logic [STAMP_BITS-2:0] sym_mag;
    } t_div;

endpackage

>>> sv/twr_if.sv
// valid/ready channels for timestamp sets and ranging results
interface twr_in_if;
    import twr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STAMP_BITS-1:0] poll_tx_time;
    logic [STAMP_BITS-1:0] poll_rx_time;
    logic [STAMP_BITS-1:0] resp_tx_time;
    logic [STAMP_BITS-1:0] resp_rx_time;
    logic [STAMP_BITS-1:0] final_tx_time;
    logic [STAMP_BITS-1:0] final_rx_time;

    modport source (output valid, poll_tx_time, poll_rx_time, resp_tx_time,
                    resp_rx_time, final_tx_time, final_rx_time, input ready);
    modport sink   (input valid, poll_tx_time, poll_rx_time, resp_tx_time,
                    resp_rx_time, final_tx_time, final_rx_time, output ready);
endinterface

interface twr_out_if;
    import twr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] flight_time;
    logic                       zero_divisor;
    logic                       saturated;

    modport source (output valid, flight_time, zero_divisor, saturated, input ready);
    modport sink   (input valid, flight_time, zero_divisor, saturated, output ready);
endinterface

>>> sv/twr_front.sv
// interval, product and divisor stages ahead of the divider
module twr_front
    import twr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic                  i_method,
    input  logic [STAMP_BITS-1:0] i_ptx,
    input  logic [STAMP_BITS-1:0] i_prx,
    input  logic [STAMP_BITS-1:0] i_rtx,
    input  logic [STAMP_BITS-1:0] i_rrx,
    input  logic [STAMP_BITS-1:0] i_ftx,
    input  logic [STAMP_BITS-1:0] i_frx,
    output logic                  o_vld,
    output t_div                  o_div
);

    // stage 1: intervals
    logic                  r1_vld, r1_method;
    logic [STAMP_BITS-1:0] r1_round1, r1_reply1, r1_round2, r1_reply2;

    // stage 2: partial products, divisor, symmetric result
    logic                              r2_vld, r2_method, r2_sneg;
    logic [HALF_BITS+STAMP_BITS-1:0]   r2_palo, r2_pblo;
    logic [PROD_BITS-HALF_BITS-1:0]    r2_pahi, r2_pbhi;
    logic [DEN_BITS-1:0]               r2_den;
    logic [STAMP_BITS-2:0]             r2_smag;
    logic                              n2_sneg;
    logic [STAMP_BITS:0]               n2_s, n2_t, n2_diff;

    // stage 3: full products
    logic                  r3_vld, r3_method, r3_sneg;
    logic [PROD_BITS-1:0]  r3_pa, r3_pb;
    logic [DEN_BITS-1:0]   r3_den;
    logic [STAMP_BITS-2:0] r3_smag;

    // stage 4: signed difference into divider form
    logic                 r4_vld;
    t_div                 r4_div, n4_div;
    logic                 n4_neg;
    logic [PROD_BITS-1:0] n4_mag;

    always_comb begin
        n2_s    = {1'b0, r1_round1} + {1'b0, r1_round2};
        n2_t    = {1'b0, r1_reply1} + {1'b0, r1_reply2};
        n2_sneg = n2_s < n2_t;
        n2_diff = n2_sneg ? (n2_t - n2_s) : (n2_s - n2_t);
    end

    always_comb begin
        n4_neg          = r3_pa < r3_pb;
        n4_mag          = n4_neg ? (r3_pb - r3_pa) : (r3_pa - r3_pb);
        n4_div.rem      = DEN_BITS'(n4_mag[PROD_BITS-1:STAMP_BITS]);
        n4_div.low      = n4_mag[STAMP_BITS-1:0];
        n4_div.quo      = '0;
        n4_div.den      = r3_den;
        n4_div.neg      = n4_neg;
        n4_div.zdiv     = (r3_den == '0);
        n4_div.sym      = (r3_method == METHOD_SYM);
        n4_div.sym_neg  = r3_sneg;
        n4_div.sym_mag  = r3_smag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_method <= i_method;
            r1_round1 <= i_rrx - i_ptx;
            r1_reply1 <= i_rtx - i_prx;
            r1_round2 <= i_frx - i_rtx;
            r1_reply2 <= i_ftx - i_rrx;

            r2_method <= r1_method;
            r2_palo   <= r1_round1[HALF_BITS-1:0] * r1_round2;
            r2_pahi   <= r1_round1[STAMP_BITS-1:HALF_BITS] * r1_round2;
            r2_pblo   <= r1_reply1[HALF_BITS-1:0] * r1_reply2;
            r2_pbhi   <= r1_reply1[STAMP_BITS-1:HALF_BITS] * r1_reply2;
            r2_den    <= DEN_BITS'(r1_round1) + DEN_BITS'(r1_round2)
                       + DEN_BITS'(r1_reply1) + DEN_BITS'(r1_reply2);
            r2_sneg   <= n2_sneg;
            r2_smag   <= n2_diff[STAMP_BITS:2];

            r3_method <= r2_method;
            r3_pa     <= PROD_BITS'(r2_palo) + (PROD_BITS'(r2_pahi) << HALF_BITS);
            r3_pb     <= PROD_BITS'(r2_pblo) + (PROD_BITS'(r2_pbhi) << HALF_BITS);
            r3_den    <= r2_den;
            r3_sneg   <= r2_sneg;
            r3_smag   <= r2_smag;

            r4_div    <= n4_div;
        end
    end

    assign o_vld = r4_vld;
    assign o_div = r4_div;

endmodule

>>> sv/twr_div.sv
// pipelined restoring divider, one quotient bit per stage
module twr_div
    import twr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_vld,
    input  t_div i_div,
    output logic o_vld,
    output t_div o_div
);

    t_div r_stg [0:STAMP_BITS-1];
    logic [STAMP_BITS-1:0] r_vld;
    t_div w_src [0:STAMP_BITS-1];

    assign w_src[0] = i_div;

    for (genvar g = 0; g < STAMP_BITS; g++) begin : g_stage
        logic [DEN_BITS:0] w_trial;
        logic              w_ge;
        t_div              n_stg;

        if (g > 0) begin : g_link
            assign w_src[g] = r_stg[g-1];
        end

        // the quotient fits the stamp width, so the remainder stays below the divisor
        always_comb begin
            w_trial   = {w_src[g].rem, w_src[g].low[STAMP_BITS-1]};
            w_ge      = w_trial >= {1'b0, w_src[g].den};
            n_stg     = w_src[g];
            n_stg.rem = w_ge ? DEN_BITS'(w_trial - {1'b0, w_src[g].den})
                             : DEN_BITS'(w_trial);
            n_stg.low = {w_src[g].low[STAMP_BITS-2:0], 1'b0};
            n_stg.quo = {w_src[g].quo[STAMP_BITS-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[g] <= n_stg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAMP_BITS-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[STAMP_BITS-1];
    assign o_div = r_stg[STAMP_BITS-1];

endmodule

>>> sv/two_way_ranging_time_of_flight.sv
// Double-sided two-way ranging: turns the six timestamps of one exchange into
// a time of flight in ticks, asymmetric or symmetric formula as set by the
// method register. Fully pipelined: one timestamp set is taken every cycle unless
// the output stalls; each set passes four arithmetic stages, one divider stage
// per quotient bit of the 40-bit stamp width and one output stage. The whole
// pipeline holds while a finished result waits at the output.
module two_way_ranging_time_of_flight
    import twr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    twr_in_if.sink    i_in,
    twr_out_if.source o_out
);

    logic r_method;
    logic w_en;
    logic w_fvld, w_dvld;
    t_div w_fdiv, w_ddiv;

    logic                       r_ovld;
    logic signed [OUT_BITS-1:0] r_flight;
    logic                       r_zdiv, r_sat;

    logic                       n_neg, n_zdiv, n_sat;
    logic [CMP_BITS-1:0]        n_mag, n_lim, n_clip;
    logic [OUT_BITS-1:0]        n_flight;

    assign w_en       = !r_ovld || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METHOD_ASYM;
        end else if (i_cfg_we) begin
            r_method <= i_cfg_wdata;
        end
    end

    twr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (i_in.valid),
        .i_method (r_method),
        .i_ptx    (i_in.poll_tx_time),
        .i_prx    (i_in.poll_rx_time),
        .i_rtx    (i_in.resp_tx_time),
        .i_rrx    (i_in.resp_rx_time),
        .i_ftx    (i_in.final_tx_time),
        .i_frx    (i_in.final_rx_time),
        .o_vld    (w_fvld),
        .o_div    (w_fdiv)
    );

    twr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fvld),
        .i_div   (w_fdiv),
        .o_vld   (w_dvld),
        .o_div   (w_ddiv)
    );

    // sign, clamp and zero-divisor override
    always_comb begin
        n_neg    = w_ddiv.sym ? w_ddiv.sym_neg : w_ddiv.neg;
        n_mag    = w_ddiv.sym ? CMP_BITS'(w_ddiv.sym_mag) : CMP_BITS'(w_ddiv.quo);
        n_zdiv   = !w_ddiv.sym && w_ddiv.zdiv;
        n_lim    = n_neg ? NEG_LIMIT : POS_LIMIT;
        n_sat    = !n_zdiv && (n_mag > n_lim);
        n_clip   = n_sat ? n_lim : n_mag;
        n_flight = n_zdiv ? '0 : (n_neg ? OUT_BITS'(-n_clip) : OUT_BITS'(n_clip));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flight <= n_flight;
            r_zdiv   <= n_zdiv;
            r_sat    <= n_sat;
        end
    end

    assign o_out.valid        = r_ovld;
    assign o_out.flight_time  = r_flight;
    assign o_out.zero_divisor = r_zdiv;
    assign o_out.saturated    = r_sat;

endmodule

>>> sim/testbench.sv
// testbench for the two-way ranging time-of-flight block: directed and random exchanges
module testbench
    import twr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 45;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [STAMP_BITS-1:0] poll_tx;
        logic [STAMP_BITS-1:0] poll_rx;
        logic [STAMP_BITS-1:0] resp_tx;
        logic [STAMP_BITS-1:0] resp_rx;
        logic [STAMP_BITS-1:0] final_tx;
        logic [STAMP_BITS-1:0] final_rx;
    } t_stamp_set;

    typedef struct packed {
        logic [OUT_BITS-1:0] flight;
        logic                zdiv;
        logic                sat;
    } t_range_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    twr_in_if  in_ch ();
    twr_out_if out_ch ();

    two_way_ranging_time_of_flight uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_stamp_set    pending_sets[$];
    t_range_result expected_flights[$];
    logic          method_now;
    bit            no_gaps;
    int            gap_left;
    int            stall_left;
    int            hold_left;
    logic          hold_tog;
    logic          hold_seen;
    int            errors;
    int            cycles;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // computes the time of flight the block should return for one set
    function automatic t_range_result predict_flight(t_stamp_set s, logic m);
        logic [STAMP_BITS-1:0] round1, round2, reply1, reply2;
        logic [DEN_BITS-1:0]   den;
        logic [79:0]           pa, pb, mag, lim;
        logic [STAMP_BITS:0]   s_sum, t_sum;
        logic                  neg;
        t_range_result         r;
        round1 = s.resp_rx - s.poll_tx;
        reply1 = s.resp_tx - s.poll_rx;
        round2 = s.final_rx - s.resp_tx;
        reply2 = s.final_tx - s.resp_rx;
        r = '0;
        if (m == METHOD_ASYM) begin
            den = DEN_BITS'(round1) + round2 + reply1 + reply2;
            if (den == '0) begin
                r.zdiv = 1'b1;
                return r;
            end
            pa  = 80'(round1) * 80'(round2);
            pb  = 80'(reply1) * 80'(reply2);
            neg = pa < pb;
            mag = (neg ? pb - pa : pa - pb) / 80'(den);
        end else begin
            s_sum = (STAMP_BITS+1)'(round1) + round2;
            t_sum = (STAMP_BITS+1)'(reply1) + reply2;
            neg   = s_sum < t_sum;
            mag   = 80'((neg ? t_sum - s_sum : s_sum - t_sum) >> 2);
        end
        lim = neg ? (80'(1) << (OUT_BITS - 1)) : (80'(1) << (OUT_BITS - 1)) - 80'(1);
        if (mag > lim) begin
            mag   = lim;
            r.sat = 1'b1;
        end
        r.flight = neg ? -mag[OUT_BITS-1:0] : mag[OUT_BITS-1:0];
        return r;
    endfunction

    function automatic logic [STAMP_BITS-1:0] rand_stamp();
        return STAMP_BITS'({$urandom(), $urandom()});
    endfunction

    // a plausible exchange: replies and flight time with some drift, random clock bases
    function automatic t_stamp_set make_exchange();
        t_stamp_set s;
        logic [STAMP_BITS-1:0] tof, rep1, rep2;
        tof  = STAMP_BITS'($urandom_range(0, 4000));
        rep1 = ($urandom_range(0, 9) == 0) ? rand_stamp() : STAMP_BITS'($urandom_range(0, 2000000));
        rep2 = ($urandom_range(0, 9) == 0) ? rand_stamp() : STAMP_BITS'($urandom_range(0, 2000000));
        s.poll_tx  = rand_stamp();
        s.poll_rx  = rand_stamp();
        s.resp_tx  = s.poll_rx + rep1;
        s.resp_rx  = s.poll_tx + rep1 + 2 * tof + STAMP_BITS'($urandom_range(0, 20));
        s.final_tx = s.resp_rx + rep2;
        s.final_rx = s.resp_tx + rep2 + 2 * tof + STAMP_BITS'($urandom_range(0, 20));
        return s;
    endfunction

    function automatic t_stamp_set make_noise();
        t_stamp_set s;
        s = {rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp()};
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(string field, logic [OUT_BITS-1:0] got, logic [OUT_BITS-1:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        errors++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_flights.push_back(predict_flight({in_ch.poll_tx_time, in_ch.poll_rx_time,
                    in_ch.resp_tx_time, in_ch.resp_rx_time, in_ch.final_tx_time,
                    in_ch.final_rx_time}, method_now));
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left    <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_sets.size() > 0) begin
                    t_stamp_set s;
                    s = pending_sets.pop_front();
                    in_ch.poll_tx_time  <= s.poll_tx;
                    in_ch.poll_rx_time  <= s.poll_rx;
                    in_ch.resp_tx_time  <= s.resp_tx;
                    in_ch.resp_rx_time  <= s.resp_rx;
                    in_ch.final_tx_time <= s.final_tx;
                    in_ch.final_rx_time <= s.final_rx;
                    in_ch.valid         <= 1'b1;
                    gap_left            <= pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started by a toggle from the stimulus
    always @(posedge i_clk) begin
        hold_seen <= hold_tog;
        if (hold_tog != hold_seen)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_flights.size() == 0) begin
                    report("unexpected item", out_ch.flight_time, '0);
                end else begin
                    t_range_result e;
                    e = expected_flights.pop_front();
                    if (out_ch.flight_time !== e.flight)
                        report("flight_time", out_ch.flight_time, e.flight);
                    if (out_ch.zero_divisor !== e.zdiv)
                        report("zero_divisor", OUT_BITS'(out_ch.zero_divisor), OUT_BITS'(e.zdiv));
                    if (out_ch.saturated !== e.sat)
                        report("saturated", OUT_BITS'(out_ch.saturated), OUT_BITS'(e.sat));
                end
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 9) == 0)
                    stall_left <= pick_gap() + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_method(logic m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        method_now = m;
    endtask

    task automatic drain();
        while (pending_sets.size() > 0 || in_ch.valid || expected_flights.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic load_directed();
        logic [STAMP_BITS-1:0] ones, hi;
        ones = '1;
        hi   = ones - 5;
        pending_sets.push_back('0);
        pending_sets.push_back('1);
        pending_sets.push_back({6{40'hAAAAAAAAAA}});
        pending_sets.push_back({40'h5555555555, 40'hAAAAAAAAAA, 40'h5555555555,
                                40'hAAAAAAAAAA, 40'h5555555555, 40'hAAAAAAAAAA});
        // stamps that wrap past the top of the counter
        pending_sets.push_back({hi, hi, hi + 100, hi + 140, hi + 240, hi + 200});
        // every interval at its largest
        pending_sets.push_back({40'd1, 40'd1, 40'd0, 40'd0, ones, ones});
        // reply far longer than round gives a negative flight
        pending_sets.push_back({40'd0, 40'd0, 40'd1000000, 40'd10, 40'd20, 40'd1000030});
        pending_sets.push_back({40'd0, 40'd0, 40'd10, 40'd1000000, 40'd1000030, 40'd20});
        pending_sets.push_back({40'd100, 40'd500, 40'd600, 40'd220, 40'd320, 40'd720});
        pending_sets.push_back({40'd0, 40'd0, 40'd0, 40'd3, 40'd3, 40'd3});
        pending_sets.push_back({ones, 40'd0, ones, 40'd0, ones, 40'd0});
        pending_sets.push_back({40'd0, ones, 40'd0, ones, 40'd0, ones});
    endtask

    task automatic load_random(int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 80)
                pending_sets.push_back(make_exchange());
            else
                pending_sets.push_back(make_noise());
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.poll_tx_time  = '0;
        in_ch.poll_rx_time  = '0;
        in_ch.resp_tx_time  = '0;
        in_ch.resp_rx_time  = '0;
        in_ch.final_tx_time = '0;
        in_ch.final_rx_time = '0;
        out_ch.ready = 1'b0;
        hold_tog     = 1'b0;
        hold_seen    = 1'b0;
        hold_left    = 0;
        method_now   = METHOD_ASYM;
        no_gaps      = 1'b0;
        errors       = 0;
        cycles       = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 8; phase++) begin
            write_method(phase[0] ? METHOD_SYM : METHOD_ASYM);
            no_gaps = (phase == 3 || phase == 6);
            if (phase < 2)
                load_directed();
            else
                load_random(250);
            // let the block fill while the receiver holds off
            if (phase == 4) begin
                @(posedge i_clk);
                hold_tog <= ~hold_tog;
            end
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
